FILE: design/ppt_pkg.sv
`default_nettype none
package ppt_pkg;

  localparam int SLOTS  = 64;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int PTR_W  = IDX_W + 1;
  localparam int SLOT_W = 6;

  // reciprocals for divide by constant, followed by one correction step
  localparam logic [31:0] RECIP_G  = 32'd3518437208;  // floor(2^45 / 10000)
  localparam logic [31:0] RECIP_10 = 32'd3435973836;  // floor(2^35 / 10)
  localparam logic [31:0] GRAV_DIV = 32'd10000;
  localparam int          GQ_W     = 19;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FORCE = 3'd1,
    OP_TICK  = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         slot_index;
    logic [7:0]         ticks;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] start_vx;
    logic signed [31:0] start_vy;
    logic signed [31:0] start_vz;
    logic [23:0]        start_mass;
    logic [14:0]        start_life;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [5:0]         slot;
    logic               replaced;
    logic               alive;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [23:0]        mass_out;
    logic signed [15:0] life_left;
  } res_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [23:0]        mass;
    logic signed [15:0] life;
  } rec_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_ALLOC_RD,
    DP_ALLOC_WR,
    DP_FORCE_RD,
    DP_FORCE_CMP,
    DP_FORCE_WR,
    DP_TICK_RD,
    DP_TICK_LOAD,
    DP_KILL1,
    DP_KILL2,
    DP_M1,
    DP_M2,
    DP_M3,
    DP_M4,
    DP_B1,
    DP_B2,
    DP_B3,
    DP_B4,
    DP_WB,
    DP_READ_RD,
    DP_READ_OUT,
    DP_CLEAR,
    DP_ZERO
  } dp_op_e;

  typedef struct packed {
    logic [2:0] op;
    logic       free_null;
    logic       active_null;
    logic       walk_end;
    logic       next_null;
    logic       guard_last;
    logic       dead;
    logic       bounce;
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_FORCE_RD,
    S_FORCE_CMP,
    S_FORCE_WR,
    S_TICK_CHK,
    S_TICK_RD,
    S_TICK_LOAD,
    S_KILL1,
    S_KILL2,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_B1,
    S_B2,
    S_B3,
    S_B4,
    S_WB,
    S_READ_RD,
    S_READ_OUT,
    S_CLEAR,
    S_ZERO
  } state_e;

endpackage
`default_nettype wire

FILE: design/particle_pool_ttl_update.sv
// Channel   Dir  Handshake                 Payload
// request   in   start, busy               req_i   (ppt_pkg::req_t)
// result    out  done_o, one-cycle strobe  res_o   (ppt_pkg::res_t)
// config    in   cfg_valid_i, cfg_ready_o  cfg_data_i (floor level, Q16.16)
//
// A request is taken when start is high and busy is low; exactly one result
// follows. Force alloc walks the active list one slot after another. Tick walks
// it through the shared arithmetic sequencer: motion and gravity steps for each
// live slot, bounce steps when it hits the floor, unlink steps for each expiring
// slot. No clearing pass: reset and clear only reset the list heads and the
// alive and link valid bits. Results cannot be stalled; the next request may be
// taken in the cycle its result strobe is up.
`default_nettype none
module particle_pool_ttl_update (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ppt_pkg::req_t req_i,
  output logic               done_o,
  output ppt_pkg::res_t      res_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [31:0]   cfg_data_i
);

  ppt_pkg::dp_op_e  cmd;
  ppt_pkg::status_t st;

  // the user must write the floor level only while idle; not enforced here, so always ready
  assign cfg_ready_o = 1'b1;

  ppt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .st_i(st), .cmd_o(cmd), .busy, .done_o
  );

  ppt_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i,
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_data_i,
    .st_o(st), .res_o
  );

endmodule
`default_nettype wire

FILE: design/ppt_ram.sv
`default_nettype none
module ppt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/ppt_ctrl.sv
`default_nettype none
module ppt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire ppt_pkg::status_t st_i,
  output ppt_pkg::dp_op_e       cmd_o,
  output logic                  busy,
  output logic                  done_o
);

  ppt_pkg::state_e state_q, state_d;
  logic            done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppt_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppt_pkg::S_IDLE:     if (start) state_d = ppt_pkg::S_DISPATCH;
      ppt_pkg::S_DISPATCH: begin
        unique case (st_i.op) inside
          ppt_pkg::OP_ALLOC, ppt_pkg::OP_FORCE: begin
            if (!st_i.free_null) begin
              state_d = ppt_pkg::S_ALLOC_RD;
            end else if (st_i.op == ppt_pkg::OP_FORCE && !st_i.active_null) begin
              state_d = ppt_pkg::S_FORCE_RD;
            end else begin
              state_d = ppt_pkg::S_ZERO;
            end
          end
          ppt_pkg::OP_TICK:  state_d = ppt_pkg::S_TICK_CHK;
          ppt_pkg::OP_READ:  state_d = ppt_pkg::S_READ_RD;
          ppt_pkg::OP_CLEAR: state_d = ppt_pkg::S_CLEAR;
          default:           state_d = ppt_pkg::S_ZERO;
        endcase
      end
      ppt_pkg::S_ALLOC_RD:  state_d = ppt_pkg::S_ALLOC_WR;
      ppt_pkg::S_ALLOC_WR:  state_d = ppt_pkg::S_IDLE;
      ppt_pkg::S_FORCE_RD:  state_d = ppt_pkg::S_FORCE_CMP;
      ppt_pkg::S_FORCE_CMP: state_d = (st_i.next_null || st_i.guard_last) ?
                                      ppt_pkg::S_FORCE_WR : ppt_pkg::S_FORCE_RD;
      ppt_pkg::S_FORCE_WR:  state_d = ppt_pkg::S_IDLE;
      ppt_pkg::S_TICK_CHK:  state_d = st_i.walk_end ? ppt_pkg::S_ZERO : ppt_pkg::S_TICK_RD;
      ppt_pkg::S_TICK_RD:   state_d = ppt_pkg::S_TICK_LOAD;
      ppt_pkg::S_TICK_LOAD: state_d = st_i.dead ? ppt_pkg::S_KILL1 : ppt_pkg::S_M1;
      ppt_pkg::S_KILL1:     state_d = ppt_pkg::S_KILL2;
      ppt_pkg::S_KILL2:     state_d = ppt_pkg::S_TICK_CHK;
      ppt_pkg::S_M1:        state_d = ppt_pkg::S_M2;
      ppt_pkg::S_M2:        state_d = ppt_pkg::S_M3;
      ppt_pkg::S_M3:        state_d = ppt_pkg::S_M4;
      ppt_pkg::S_M4:        state_d = st_i.bounce ? ppt_pkg::S_B1 : ppt_pkg::S_WB;
      ppt_pkg::S_B1:        state_d = ppt_pkg::S_B2;
      ppt_pkg::S_B2:        state_d = ppt_pkg::S_B3;
      ppt_pkg::S_B3:        state_d = ppt_pkg::S_B4;
      ppt_pkg::S_B4:        state_d = ppt_pkg::S_WB;
      ppt_pkg::S_WB:        state_d = ppt_pkg::S_TICK_CHK;
      ppt_pkg::S_READ_RD:   state_d = ppt_pkg::S_READ_OUT;
      ppt_pkg::S_READ_OUT:  state_d = ppt_pkg::S_IDLE;
      ppt_pkg::S_CLEAR:     state_d = ppt_pkg::S_ZERO;
      ppt_pkg::S_ZERO:      state_d = ppt_pkg::S_IDLE;
      default:              state_d = ppt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = ppt_pkg::DP_NOP;
    done_d = 1'b0;
    unique case (state_q)
      ppt_pkg::S_IDLE:      cmd_o = start ? ppt_pkg::DP_LOAD : ppt_pkg::DP_NOP;
      ppt_pkg::S_DISPATCH:  cmd_o = ppt_pkg::DP_NOP;
      ppt_pkg::S_ALLOC_RD:  cmd_o = ppt_pkg::DP_ALLOC_RD;
      ppt_pkg::S_ALLOC_WR:  begin cmd_o = ppt_pkg::DP_ALLOC_WR; done_d = 1'b1; end
      ppt_pkg::S_FORCE_RD:  cmd_o = ppt_pkg::DP_FORCE_RD;
      ppt_pkg::S_FORCE_CMP: cmd_o = ppt_pkg::DP_FORCE_CMP;
      ppt_pkg::S_FORCE_WR:  begin cmd_o = ppt_pkg::DP_FORCE_WR; done_d = 1'b1; end
      ppt_pkg::S_TICK_CHK:  cmd_o = ppt_pkg::DP_NOP;
      ppt_pkg::S_TICK_RD:   cmd_o = ppt_pkg::DP_TICK_RD;
      ppt_pkg::S_TICK_LOAD: cmd_o = ppt_pkg::DP_TICK_LOAD;
      ppt_pkg::S_KILL1:     cmd_o = ppt_pkg::DP_KILL1;
      ppt_pkg::S_KILL2:     cmd_o = ppt_pkg::DP_KILL2;
      ppt_pkg::S_M1:        cmd_o = ppt_pkg::DP_M1;
      ppt_pkg::S_M2:        cmd_o = ppt_pkg::DP_M2;
      ppt_pkg::S_M3:        cmd_o = ppt_pkg::DP_M3;
      ppt_pkg::S_M4:        cmd_o = ppt_pkg::DP_M4;
      ppt_pkg::S_B1:        cmd_o = ppt_pkg::DP_B1;
      ppt_pkg::S_B2:        cmd_o = ppt_pkg::DP_B2;
      ppt_pkg::S_B3:        cmd_o = ppt_pkg::DP_B3;
      ppt_pkg::S_B4:        cmd_o = ppt_pkg::DP_B4;
      ppt_pkg::S_WB:        cmd_o = ppt_pkg::DP_WB;
      ppt_pkg::S_READ_RD:   cmd_o = ppt_pkg::DP_READ_RD;
      ppt_pkg::S_READ_OUT:  begin cmd_o = ppt_pkg::DP_READ_OUT; done_d = 1'b1; end
      ppt_pkg::S_CLEAR:     cmd_o = ppt_pkg::DP_CLEAR;
      ppt_pkg::S_ZERO:      begin cmd_o = ppt_pkg::DP_ZERO; done_d = 1'b1; end
      default:              cmd_o = ppt_pkg::DP_NOP;
    endcase
  end

  assign busy   = (state_q != ppt_pkg::S_IDLE);
  assign done_o = done_q;

  // every finishing state hands back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ppt_pkg::S_IDLE) else $error("done outside idle");
  a_start_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> state_q == ppt_pkg::S_DISPATCH) else $error("request not taken");
  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ppt_pkg::S_DISPATCH |-> !done_q) else $error("stale done");
  a_wb_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ppt_pkg::S_WB |=> state_q == ppt_pkg::S_TICK_CHK)
    else $error("walk lost");

endmodule
`default_nettype wire

FILE: design/ppt_dpath.sv
`default_nettype none
module ppt_dpath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ppt_pkg::dp_op_e cmd_i,
  input  wire ppt_pkg::req_t   req_i,
  input  wire logic            cfg_we_i,
  input  wire logic [31:0]     cfg_data_i,
  output ppt_pkg::status_t     st_o,
  output ppt_pkg::res_t        res_o
);

  localparam logic [ppt_pkg::PTR_W-1:0] NULL_P = ppt_pkg::PTR_W'(ppt_pkg::SLOTS);

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -42'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor(3n/10) from n and the registered product n*RECIP_10
  function automatic logic [30:0] mul3_div10(input logic [31:0] n, input logic [63:0] prod);
    logic [28:0] q0;
    logic [32:0] r;
    logic [28:0] a;
    logic [4:0]  b;
    logic [1:0]  c;
    q0 = prod[63:35];
    r  = {1'b0, n} - ({1'b0, q0, 3'b000} + {3'b000, q0, 1'b0});
    if (r[4:0] >= 5'd10) begin
      a = q0 + 29'd1;
      b = r[4:0] - 5'd10;
    end else begin
      a = q0;
      b = r[4:0];
    end
    c = (b >= 5'd7) ? 2'd2 : ((b >= 5'd4) ? 2'd1 : 2'd0);
    return 31'({2'b00, a} + {1'b0, a, 1'b0} + 31'(c));
  endfunction

  ppt_pkg::req_t              req_q;
  logic signed [31:0]         floor_q;
  logic [ppt_pkg::PTR_W-1:0]  free_q, act_q, p_q, prev_q, best_q, nx_q, guard_q;
  logic signed [15:0]         blife_q;
  logic [ppt_pkg::SLOTS-1:0]  alive_q, lval_q;
  logic                       lv_rd_q;
  logic [ppt_pkg::PTR_W-1:0]  lra_q;
  ppt_pkg::rec_t              w_q;
  logic [31:0]                gp_q, qd_q, dn_q;
  logic [63:0]                prod_q;
  logic [ppt_pkg::GQ_W-1:0]   q0_q;
  logic                       bounce_q;
  ppt_pkg::res_t              res_q;

  logic                       l_we, r_we;
  logic [ppt_pkg::IDX_W-1:0]  l_wa, l_ra, r_wa, r_ra;
  logic [ppt_pkg::PTR_W-1:0]  l_wd, l_rdata, link_rd;
  ppt_pkg::rec_t              r_wd, rec_rd;
  logic [$bits(ppt_pkg::rec_t)-1:0] r_rdata;
  ppt_pkg::rec_t              rec_req;

  logic signed [16:0]         life_new;
  logic signed [31:0]         pxn, pyn, pzn;
  logic [8:0]                 tk;
  logic [31:0]                gr;
  logic [ppt_pkg::GQ_W:0]     gq;
  logic [30:0]                fdiv;
  logic [ppt_pkg::SLOT_W:0]   idx_ext;
  logic [ppt_pkg::IDX_W-1:0]  ridx;

  ppt_ram #(.Width(ppt_pkg::PTR_W), .Depth(ppt_pkg::SLOTS)) u_link (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(l_rdata)
  );

  ppt_ram #(.Width($bits(ppt_pkg::rec_t)), .Depth(ppt_pkg::SLOTS)) u_rec (
    .clk_i, .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd), .raddr_i(r_ra), .rdata_o(r_rdata)
  );

  // unwritten link entries read as their reset chain value
  assign link_rd = lv_rd_q ? l_rdata : lra_q + ppt_pkg::PTR_W'(1);
  assign rec_rd  = r_rdata;

  assign tk       = {1'b0, req_q.ticks};
  assign life_new = 17'(rec_rd.life) - 17'(tk);
  assign pxn = sat32(42'($signed(w_q.px)) + 42'($signed(w_q.vx)) * $signed(tk));
  assign pyn = sat32(42'($signed(w_q.py)) + 42'($signed(w_q.vy)) * $signed(tk));
  assign pzn = sat32(42'($signed(w_q.pz)) + 42'($signed(w_q.vz)) * $signed(tk));
  assign gr  = gp_q - qd_q;
  assign gq  = {1'b0, q0_q} + ((gr >= ppt_pkg::GRAV_DIV) ? (ppt_pkg::GQ_W+1)'(1) : '0);
  assign fdiv = mul3_div10(dn_q, prod_q);
  assign idx_ext = {1'b0, req_q.slot_index};
  assign ridx    = ppt_pkg::IDX_W'(req_q.slot_index);

  always_comb begin
    rec_req.px   = req_q.start_x;
    rec_req.py   = req_q.start_y;
    rec_req.pz   = req_q.start_z;
    rec_req.vx   = req_q.start_vx;
    rec_req.vy   = req_q.start_vy;
    rec_req.vz   = req_q.start_vz;
    rec_req.mass = req_q.start_mass;
    rec_req.life = 16'(req_q.start_life);
  end

  always_comb begin
    l_we = 1'b0;
    l_wa = p_q[ppt_pkg::IDX_W-1:0];
    l_wd = free_q;
    l_ra = p_q[ppt_pkg::IDX_W-1:0];
    r_we = 1'b0;
    r_wa = p_q[ppt_pkg::IDX_W-1:0];
    r_wd = w_q;
    r_ra = p_q[ppt_pkg::IDX_W-1:0];
    case (cmd_i)
      ppt_pkg::DP_ALLOC_RD: l_ra = free_q[ppt_pkg::IDX_W-1:0];
      ppt_pkg::DP_ALLOC_WR: begin
        l_we = 1'b1;
        l_wa = free_q[ppt_pkg::IDX_W-1:0];
        l_wd = act_q;
        r_we = 1'b1;
        r_wa = free_q[ppt_pkg::IDX_W-1:0];
        r_wd = rec_req;
      end
      ppt_pkg::DP_FORCE_WR: begin
        r_we = 1'b1;
        r_wa = best_q[ppt_pkg::IDX_W-1:0];
        r_wd = rec_req;
      end
      ppt_pkg::DP_KILL1: begin
        l_we = (prev_q != NULL_P);
        l_wa = prev_q[ppt_pkg::IDX_W-1:0];
        l_wd = nx_q;
      end
      ppt_pkg::DP_KILL2: l_we = 1'b1;
      ppt_pkg::DP_WB:    r_we = 1'b1;
      ppt_pkg::DP_READ_RD: r_ra = ridx;
      default: ;
    endcase
  end

  // list control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= '0;
      free_q  <= '0;
      act_q   <= NULL_P;
      alive_q <= '0;
      lval_q  <= '0;
    end else begin
      if (cfg_we_i) floor_q <= cfg_data_i;
      if (l_we) lval_q[l_wa] <= 1'b1;
      case (cmd_i)
        ppt_pkg::DP_ALLOC_WR: begin
          free_q <= link_rd;
          act_q  <= free_q;
          alive_q[free_q[ppt_pkg::IDX_W-1:0]] <= 1'b1;
        end
        ppt_pkg::DP_KILL1: begin
          if (prev_q == NULL_P) act_q <= nx_q;
          alive_q[p_q[ppt_pkg::IDX_W-1:0]] <= 1'b0;
        end
        ppt_pkg::DP_KILL2: free_q <= p_q;
        ppt_pkg::DP_CLEAR: begin
          free_q  <= '0;
          act_q   <= NULL_P;
          alive_q <= '0;
          lval_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  // walk pointers, working record and result
  always_ff @(posedge clk_i) begin
    lra_q   <= {1'b0, l_ra};
    lv_rd_q <= lval_q[l_ra];
    case (cmd_i)
      ppt_pkg::DP_LOAD: begin
        req_q   <= req_i;
        p_q     <= act_q;
        best_q  <= act_q;
        prev_q  <= NULL_P;
        guard_q <= '0;
        blife_q <= 16'sh7fff;
      end
      ppt_pkg::DP_ALLOC_WR: begin
        res_q      <= '0;
        res_q.ok   <= 1'b1;
        res_q.slot <= ppt_pkg::SLOT_W'(free_q[ppt_pkg::IDX_W-1:0]);
      end
      ppt_pkg::DP_FORCE_CMP: begin
        if (rec_rd.life < blife_q) begin
          best_q  <= p_q;
          blife_q <= rec_rd.life;
        end
        p_q     <= link_rd;
        guard_q <= guard_q + ppt_pkg::PTR_W'(1);
      end
      ppt_pkg::DP_FORCE_WR: begin
        res_q          <= '0;
        res_q.ok       <= 1'b1;
        res_q.replaced <= 1'b1;
        res_q.slot     <= ppt_pkg::SLOT_W'(best_q[ppt_pkg::IDX_W-1:0]);
      end
      ppt_pkg::DP_TICK_LOAD: begin
        w_q      <= rec_rd;
        w_q.life <= life_new[15:0];
        nx_q     <= link_rd;
        guard_q  <= guard_q + ppt_pkg::PTR_W'(1);
      end
      ppt_pkg::DP_KILL2: p_q <= nx_q;
      ppt_pkg::DP_M1: begin
        w_q.px   <= pxn;
        w_q.py   <= pyn;
        w_q.pz   <= pzn;
        gp_q     <= {8'b0, w_q.mass} * {24'b0, req_q.ticks};
        bounce_q <= (pzn < floor_q);
      end
      ppt_pkg::DP_M2: prod_q <= {32'b0, gp_q} * {32'b0, ppt_pkg::RECIP_G};
      ppt_pkg::DP_M3: begin
        q0_q <= prod_q[45 +: ppt_pkg::GQ_W];
        qd_q <= 32'({13'b0, prod_q[45 +: ppt_pkg::GQ_W]} * ppt_pkg::GRAV_DIV);
      end
      ppt_pkg::DP_M4: begin
        w_q.vz <= sat32(42'($signed(w_q.vz)) - 42'($signed({1'b0, gq})));
        dn_q   <= 32'(floor_q - w_q.pz);
      end
      ppt_pkg::DP_B1, ppt_pkg::DP_B3: prod_q <= {32'b0, dn_q} * {32'b0, ppt_pkg::RECIP_10};
      ppt_pkg::DP_B2: begin
        w_q.pz <= sat32(42'($signed(floor_q)) + 42'($signed({1'b0, fdiv})));
        dn_q   <= w_q.vz[31] ? 32'(-w_q.vz) : 32'(w_q.vz);
      end
      ppt_pkg::DP_B4: begin
        w_q.vz <= w_q.vz[31] ? $signed({1'b0, fdiv}) : -$signed({1'b0, fdiv});
      end
      ppt_pkg::DP_WB: begin
        prev_q <= p_q;
        p_q    <= nx_q;
      end
      ppt_pkg::DP_READ_OUT: begin
        res_q      <= '0;
        res_q.slot <= req_q.slot_index;
        if (idx_ext < (ppt_pkg::SLOT_W+1)'(ppt_pkg::SLOTS) && alive_q[ridx]) begin
          res_q.alive     <= 1'b1;
          res_q.pos_x     <= rec_rd.px;
          res_q.pos_y     <= rec_rd.py;
          res_q.pos_z     <= rec_rd.pz;
          res_q.vel_x     <= rec_rd.vx;
          res_q.vel_y     <= rec_rd.vy;
          res_q.vel_z     <= rec_rd.vz;
          res_q.mass_out  <= rec_rd.mass;
          res_q.life_left <= rec_rd.life;
        end
      end
      ppt_pkg::DP_ZERO: res_q <= '0;
      default: ;
    endcase
  end

  always_comb begin
    st_o.op          = req_q.op;
    st_o.free_null   = (free_q >= NULL_P);
    st_o.active_null = (act_q >= NULL_P);
    st_o.walk_end    = (p_q >= NULL_P) || (guard_q == NULL_P);
    st_o.next_null   = (link_rd >= NULL_P);
    st_o.guard_last  = (guard_q == NULL_P - ppt_pkg::PTR_W'(1));
    st_o.dead        = (life_new <= 17'sd0);
    st_o.bounce      = bounce_q;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

FILE: sim/ppt_checker.sv
`timescale 1ns / 1ps
// Watches request, config and result channels, keeps its own copy of the pool
// and compares every result with the oldest prediction.
module ppt_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  ppt_pkg::req_t req_i,
  input  logic          done_o,
  input  ppt_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_o,
  input  logic [31:0]   cfg_data_i,
  output int            fail_cnt,
  output int            pending_cnt
);
  import ppt_pkg::*;

  localparam int NIL = SLOTS;

  int     next_of [SLOTS];
  bit     live    [SLOTS];
  int     act_head, free_head;
  longint pos     [SLOTS][3];
  longint vel     [SLOTS][3];
  longint mass    [SLOTS];
  longint life    [SLOTS];
  longint floor_q;
  res_t   expected_q[$];

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void reset_lists();
    for (int i = 0; i < SLOTS; i++) begin
      next_of[i] = i + 1;
      live[i]    = 1'b0;
    end
    act_head  = NIL;
    free_head = 0;
  endfunction

  function automatic void load_slot(int s, req_t r);
    pos[s][0] = longint'(r.start_x);
    pos[s][1] = longint'(r.start_y);
    pos[s][2] = longint'(r.start_z);
    vel[s][0] = longint'(r.start_vx);
    vel[s][1] = longint'(r.start_vy);
    vel[s][2] = longint'(r.start_vz);
    mass[s]   = longint'(r.start_mass);
    life[s]   = longint'(r.start_life);
  endfunction

  // advance one surviving particle by t ticks: motion, gravity, floor bounce
  function automatic void advance(int s, longint t);
    longint vz;
    for (int k = 0; k < 3; k++) pos[s][k] = sat32(pos[s][k] + vel[s][k] * t);
    vel[s][2] = sat32(vel[s][2] - (mass[s] * t) / 10000);
    if (pos[s][2] < floor_q) begin
      pos[s][2] = sat32(floor_q + ((floor_q - pos[s][2]) * 3) / 10);
      vz        = vel[s][2];
      vel[s][2] = sat32(-(vz * 3) / 10);
    end
  endfunction

  function automatic res_t pool_outcome(req_t r);
    res_t o;
    int   s, p, prev, nx, best, guard;
    o = '0;
    case (r.op)
      OP_ALLOC, OP_FORCE: begin
        if (free_head < NIL) begin
          s         = free_head;
          free_head = next_of[s];
          next_of[s] = act_head;
          act_head  = s;
          live[s]   = 1'b1;
          load_slot(s, r);
          o.ok   = 1'b1;
          o.slot = s[5:0];
        end else if (r.op == OP_FORCE && act_head < NIL) begin
          // smallest life wins, first in list order on a tie
          p = act_head; best = act_head; guard = 0;
          while (p < NIL && guard < SLOTS) begin
            guard++;
            if (life[p] < life[best]) best = p;
            p = next_of[p];
          end
          load_slot(best, r);
          o.ok       = 1'b1;
          o.slot     = best[5:0];
          o.replaced = 1'b1;
        end
      end
      OP_TICK: begin
        p = act_head; prev = NIL; guard = 0;
        while (p < NIL && guard < SLOTS) begin
          guard++;
          nx = next_of[p];
          life[p] -= longint'(r.ticks);
          if (life[p] <= 0) begin
            if (prev >= NIL) act_head = nx;
            else next_of[prev] = nx;
            next_of[p] = free_head;
            free_head  = p;
            live[p]    = 1'b0;
          end else begin
            advance(p, longint'(r.ticks));
            prev = p;
          end
          p = nx;
        end
      end
      OP_READ: begin
        s      = int'(r.slot_index);
        o.slot = r.slot_index;
        if (live[s]) begin
          o.alive     = 1'b1;
          o.pos_x     = pos[s][0][31:0];
          o.pos_y     = pos[s][1][31:0];
          o.pos_z     = pos[s][2][31:0];
          o.vel_x     = vel[s][0][31:0];
          o.vel_y     = vel[s][1][31:0];
          o.vel_z     = vel[s][2][31:0];
          o.mass_out  = mass[s][23:0];
          o.life_left = life[s][15:0];
        end
      end
      OP_CLEAR: reset_lists();
      default: ;
    endcase
    return o;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  assign pending_cnt = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      reset_lists();
      for (int i = 0; i < SLOTS; i++) begin
        for (int k = 0; k < 3; k++) begin
          pos[i][k] = 0;
          vel[i][k] = 0;
        end
        mass[i] = 0;
        life[i] = 0;
      end
      floor_q  = 0;
      fail_cnt = 0;
      expected_q.delete();
    end else begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt++;
        end else begin
          e = expected_q.pop_front();
          check_field("ok",        e.ok,        res_o.ok);
          check_field("slot",      e.slot,      res_o.slot);
          check_field("replaced",  e.replaced,  res_o.replaced);
          check_field("alive",     e.alive,     res_o.alive);
          check_field("pos_x",     e.pos_x,     res_o.pos_x);
          check_field("pos_y",     e.pos_y,     res_o.pos_y);
          check_field("pos_z",     e.pos_z,     res_o.pos_z);
          check_field("vel_x",     e.vel_x,     res_o.vel_x);
          check_field("vel_y",     e.vel_y,     res_o.vel_y);
          check_field("vel_z",     e.vel_z,     res_o.vel_z);
          check_field("mass_out",  e.mass_out,  res_o.mass_out);
          check_field("life_left", e.life_left, res_o.life_left);
        end
      end
      if (cfg_valid_i && cfg_ready_o) floor_q = longint'(signed'(cfg_data_i));
      if (start && !busy) expected_q.push_back(pool_outcome(req_i));
    end
  end
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the particle pool. Prediction and comparison live
// in ppt_checker; this module only drives the request and config channels.
module tb_top;
  import ppt_pkg::*;

  // op encodings the block must ignore
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  res_t        res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  int          fail_cnt, pending_cnt;
  int          idle_pct = 35;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  particle_pool_ttl_update dut (.*);

  ppt_checker chk (.*);

  // hard stop well beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

  // present one request from a falling edge, hold it until taken
  task automatic issue(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // floor writes only once the pool has drained all outstanding requests
  task automatic set_floor(logic [31:0] v);
    start = 1'b0;
    while (pending_cnt != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // half full-range values (saturation), half small Q16.16 magnitudes
  function automatic logic [31:0] rand_q();
    if ($urandom_range(1)) return $urandom;
    return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
  endfunction

  function automatic req_t particle(logic [2:0] op, int life_max);
    req_t r;
    r.op         = op;
    r.slot_index = 6'($urandom_range(63));
    r.ticks      = 8'($urandom);
    r.start_x    = rand_q();
    r.start_y    = rand_q();
    r.start_z    = rand_q();
    r.start_vx   = rand_q();
    r.start_vy   = rand_q();
    r.start_vz   = rand_q();
    r.start_mass = 24'($urandom);
    r.start_life = 15'($urandom_range(1, life_max));
    return r;
  endfunction

  function automatic req_t with_op(logic [2:0] op, logic [7:0] t, logic [5:0] idx);
    req_t r;
    r            = particle(op, 300);
    r.ticks      = t;
    r.slot_index = idx;
    return r;
  endfunction

  initial begin
    req_t r;
    int   pick;
    logic [31:0] floors [4];
    floors = '{32'sh0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0};

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_floor(32'h0);

    // directed: field extremes, each op, read-back of live and dead slots
    r = particle(OP_ALLOC, 32767);
    r.start_x = 32'h7FFF_FFFF; r.start_y = 32'h8000_0000; r.start_z = 32'h8000_0000;
    r.start_vx = 32'h7FFF_FFFF; r.start_vy = 32'h8000_0000; r.start_vz = 32'h8000_0000;
    r.start_mass = 24'hFF_FFFF; r.start_life = 15'h7FFF;
    issue(r);
    r = particle(OP_ALLOC, 1);
    r.start_x = '0; r.start_y = '0; r.start_z = '0;
    r.start_vx = '0; r.start_vy = '0; r.start_vz = '0; r.start_mass = '0;
    issue(r);
    issue(with_op(OP_READ, 8'd0, 6'd0));
    issue(with_op(OP_READ, 8'd0, 6'd1));
    issue(with_op(OP_READ, 8'd0, 6'd63));
    issue(with_op(OP_TICK, 8'd0, 6'd0));
    issue(with_op(OP_READ, 8'd0, 6'd1));
    issue(with_op(OP_TICK, 8'd1, 6'd0));        // life-1 particle expires
    issue(with_op(OP_READ, 8'd0, 6'd1));
    issue(with_op(OP_READ, 8'd0, 6'd0));
    issue(with_op(OP_TICK, 8'd255, 6'd0));
    issue(with_op(OP_READ, 8'd0, 6'd0));
    issue(with_op(OP_FORCE, 8'd0, 6'd0));
    issue(with_op(OP_SPARE_LO, 8'd3, 6'd5));
    issue(with_op(OP_SPARE_HI, 8'd255, 6'd63));
    issue(with_op(OP_CLEAR, 8'd0, 6'd0));
    issue(with_op(OP_READ, 8'd0, 6'd0));        // stale store, slot now dead
    issue(with_op(OP_FORCE, 8'd0, 6'd0));
    issue(with_op(OP_READ, 8'd0, 6'd0));

    // random phases, one floor level each
    for (int ph = 0; ph < 4; ph++) begin
      set_floor(floors[ph]);
      for (int n = 0; n < 400; n++) begin
        // one long stretch with back-to-back requests
        idle_pct = (ph == 1 && n >= 100 && n < 300) ? 0 : 35;
        pick = $urandom_range(99);
        if (pick < 30)      r = particle(OP_ALLOC, ($urandom_range(9) == 0) ? 32767 : 400);
        else if (pick < 45) r = particle(OP_FORCE, ($urandom_range(9) == 0) ? 32767 : 400);
        else if (pick < 60) begin
          r = particle(OP_TICK, 1);
          if ($urandom_range(9) != 0) r.ticks = 8'($urandom_range(0, 12));
        end
        else if (pick < 95) r = particle(OP_READ, 1);
        else if (pick < 97) r = particle(OP_CLEAR, 1);
        else r = particle(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 1);
        issue(r);
      end
    end

    start = 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
